>>> rtl/crfd_pkg.sv
`default_nettype none

package crfd_pkg;

  localparam int unsigned STEPS      = 10;
  localparam int unsigned S3         = STEPS * STEPS * STEPS;
  localparam int unsigned DIV_M      = 2 * S3;

  localparam int unsigned PT_W       = 24;
  localparam int unsigned COEF_W     = 28;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned DIV_W      = 56;
  localparam int unsigned FRAC_SHIFT = 16;

  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned DIV_ITERS  = DIV_W / DIV_BITS;
  localparam int unsigned REM_W      = $clog2(DIV_M) + 1;
  localparam int unsigned ITER_W     = $clog2(DIV_ITERS + 1);

  localparam int unsigned STEP_W     = $clog2(STEPS + 1);

  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned QPTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(Q_DEPTH + 1);

  typedef logic signed [PT_W-1:0]  point_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    acc_t x0;
    acc_t d1;
    acc_t d2;
    acc_t d3;
  } diff_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } diff_set_t;

endpackage

`default_nettype wire

>>> rtl/crfd_div.sv
`default_nettype none

module crfd_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [crfd_pkg::DIV_W-1:0]   dividend_i,
  output logic                                done_o,
  output crfd_pkg::acc_t                      quotient_o
);

  logic                             run_q, run_d;
  logic [crfd_pkg::ITER_W-1:0]      cnt_q, cnt_d;
  logic                             neg_q, neg_d;
  logic [crfd_pkg::DIV_W-1:0]       quo_q, quo_d;
  logic [crfd_pkg::REM_W-1:0]       rem_q, rem_d;
  logic [crfd_pkg::DIV_W-1:0]       quo_signed;

  // floor division by a constant: negative dividends go through ~d + m
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    neg_d = neg_q;
    if (start_i) begin
      neg_d = dividend_i[crfd_pkg::DIV_W-1];
      quo_d = dividend_i[crfd_pkg::DIV_W-1] ?
              (~dividend_i + crfd_pkg::DIV_W'(crfd_pkg::DIV_M)) : dividend_i;
      rem_d = '0;
      cnt_d = crfd_pkg::ITER_W'(crfd_pkg::DIV_ITERS);
      run_d = 1'b1;
    end else if (run_q && (cnt_q != '0)) begin
      for (int i = 0; i < crfd_pkg::DIV_BITS; i++) begin
        rem_d = {rem_d[crfd_pkg::REM_W-2:0], quo_d[crfd_pkg::DIV_W-1]};
        quo_d = {quo_d[crfd_pkg::DIV_W-2:0], 1'b0};
        if (rem_d >= crfd_pkg::REM_W'(crfd_pkg::DIV_M)) begin
          rem_d    = rem_d - crfd_pkg::REM_W'(crfd_pkg::DIV_M);
          quo_d[0] = 1'b1;
        end
      end
      cnt_d = cnt_q - crfd_pkg::ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign quo_signed = neg_q ? (~quo_q + crfd_pkg::DIV_W'(1)) : quo_q;
  assign quotient_o = quo_signed[crfd_pkg::ACC_W-1:0];
  assign done_o     = run_q && (cnt_q == '0);

endmodule

`default_nettype wire

>>> rtl/crfd_front.sv
`default_nettype none

module crfd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic                  first_point_i,
  input  crfd_pkg::point_t      point_x_i,
  input  crfd_pkg::point_t      point_y_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output crfd_pkg::diff_set_t   q_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  typedef logic signed [crfd_pkg::COEF_W-1:0] coef_w_t;
  typedef logic signed [crfd_pkg::DIV_W-1:0]  div_w_t;

  typedef struct packed {
    coef_w_t a;
    coef_w_t b;
    coef_w_t c;
  } coef_t;

  typedef struct packed {
    div_w_t d1;
    div_w_t d2;
    div_w_t d3;
  } div_in_t;

  function automatic coef_t calc_coef(input crfd_pkg::point_t w0, input crfd_pkg::point_t w1,
                                      input crfd_pkg::point_t w2, input crfd_pkg::point_t p3);
    coef_t   r;
    coef_w_t e0, e1, e2, e3;
    e0  = crfd_pkg::COEF_W'(w0);
    e1  = crfd_pkg::COEF_W'(w1);
    e2  = crfd_pkg::COEF_W'(w2);
    e3  = crfd_pkg::COEF_W'(p3);
    r.a = e3 - e0 + crfd_pkg::COEF_W'(3) * (e1 - e2);
    r.b = crfd_pkg::COEF_W'(2) * e0 - crfd_pkg::COEF_W'(5) * e1
          + crfd_pkg::COEF_W'(4) * e2 - e3;
    r.c = e2 - e0;
    return r;
  endfunction

  function automatic div_w_t to_dividend(input div_w_t num);
    return (num <<< crfd_pkg::FRAC_SHIFT) + crfd_pkg::DIV_W'(crfd_pkg::S3);
  endfunction

  function automatic div_in_t calc_div_in(input coef_t cf);
    div_in_t r;
    div_w_t  a, b, c;
    a    = crfd_pkg::DIV_W'(cf.a);
    b    = crfd_pkg::DIV_W'(cf.b);
    c    = crfd_pkg::DIV_W'(cf.c);
    r.d1 = to_dividend(a + b * crfd_pkg::DIV_W'(crfd_pkg::STEPS)
                       + c * crfd_pkg::DIV_W'(crfd_pkg::STEPS * crfd_pkg::STEPS));
    r.d2 = to_dividend(a * crfd_pkg::DIV_W'(6) + b * crfd_pkg::DIV_W'(2 * crfd_pkg::STEPS));
    r.d3 = to_dividend(a * crfd_pkg::DIV_W'(6));
    return r;
  endfunction

  logic [1:0]       state_q;
  logic [1:0]       held_q;
  logic             start_q;
  crfd_pkg::point_t wx_q [3];
  crfd_pkg::point_t wy_q [3];
  coef_t            cx_q, cy_q;
  crfd_pkg::acc_t   x0x_q, x0y_q;
  div_in_t          dvx_q, dvy_q;

  logic             accept;
  logic             div_done;
  logic             div_fin;
  logic [5:0]       done;
  crfd_pkg::acc_t   qx1, qx2, qx3, qy1, qy2, qy3;

  assign full_o   = (state_q != ST_IDLE);
  assign accept   = push_i && !full_o;
  assign div_done = &done;
  assign div_fin  = (state_q == ST_DIV) && div_done && !start_q;
  assign q_push_o = !q_full_i && (div_fin || (state_q == ST_HOLD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= 2'd0;
      start_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        wx_q[i] <= '0;
        wy_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (first_point_i) begin
              wx_q[0] <= '0;
              wx_q[1] <= '0;
              wx_q[2] <= point_x_i;
              wy_q[0] <= '0;
              wy_q[1] <= '0;
              wy_q[2] <= point_y_i;
              held_q  <= 2'd1;
            end else begin
              wx_q[0] <= wx_q[1];
              wx_q[1] <= wx_q[2];
              wx_q[2] <= point_x_i;
              wy_q[0] <= wy_q[1];
              wy_q[1] <= wy_q[2];
              wy_q[2] <= point_y_i;
              if (held_q != 2'd3) begin
                held_q <= held_q + 2'd1;
              end else begin
                state_q <= ST_NUM;
              end
            end
          end
        end
        ST_NUM: begin
          start_q <= 1'b1;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          start_q <= 1'b0;
          if (div_fin) begin
            state_q <= q_full_i ? ST_HOLD : ST_IDLE;
          end
        end
        ST_HOLD: begin
          if (!q_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q  <= calc_coef(wx_q[0], wx_q[1], wx_q[2], point_x_i);
      cy_q  <= calc_coef(wy_q[0], wy_q[1], wy_q[2], point_y_i);
      x0x_q <= crfd_pkg::ACC_W'(wx_q[1]) <<< crfd_pkg::FRAC_SHIFT;
      x0y_q <= crfd_pkg::ACC_W'(wy_q[1]) <<< crfd_pkg::FRAC_SHIFT;
    end
    if (state_q == ST_NUM) begin
      dvx_q <= calc_div_in(cx_q);
      dvy_q <= calc_div_in(cy_q);
    end
  end

  crfd_div u_div_x1 (.clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvx_q.d1),
                     .done_o(done[0]), .quotient_o(qx1));
  crfd_div u_div_x2 (.clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvx_q.d2),
                     .done_o(done[1]), .quotient_o(qx2));
  crfd_div u_div_x3 (.clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvx_q.d3),
                     .done_o(done[2]), .quotient_o(qx3));
  crfd_div u_div_y1 (.clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvy_q.d1),
                     .done_o(done[3]), .quotient_o(qy1));
  crfd_div u_div_y2 (.clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvy_q.d2),
                     .done_o(done[4]), .quotient_o(qy2));
  crfd_div u_div_y3 (.clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvy_q.d3),
                     .done_o(done[5]), .quotient_o(qy3));

  always_comb begin
    q_data_o.x.x0 = x0x_q;
    q_data_o.x.d1 = qx1;
    q_data_o.x.d2 = qx2;
    q_data_o.x.d3 = qx3;
    q_data_o.y.x0 = x0y_q;
    q_data_o.y.d1 = qy1;
    q_data_o.y.d2 = qy2;
    q_data_o.y.d3 = qy3;
  end

endmodule

`default_nettype wire

>>> rtl/crfd_queue.sv
`default_nettype none

module crfd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  crfd_pkg::diff_set_t   data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output crfd_pkg::diff_set_t   data_o
);

  crfd_pkg::diff_set_t          mem_q [crfd_pkg::Q_DEPTH];
  logic [crfd_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [crfd_pkg::QCNT_W-1:0]  cnt_q;
  logic                         do_push, do_pop;

  function automatic logic [crfd_pkg::QPTR_W-1:0] ptr_next(
      input logic [crfd_pkg::QPTR_W-1:0] p);
    return (p == crfd_pkg::QPTR_W'(crfd_pkg::Q_DEPTH - 1)) ? '0 : p + crfd_pkg::QPTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == crfd_pkg::QCNT_W'(crfd_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + crfd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - crfd_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/crfd_back.sv
`default_nettype none

module crfd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  crfd_pkg::diff_set_t   q_data_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output crfd_pkg::point_t      vertex_x_o,
  output crfd_pkg::point_t      vertex_y_o,
  output logic                  strip_start_o,
  output logic                  last_o
);

  localparam int unsigned R_W = crfd_pkg::ACC_W + 1 - crfd_pkg::FRAC_SHIFT;

  // round to nearest, ties up, then saturate to the point range
  function automatic crfd_pkg::point_t to_vertex(input crfd_pkg::acc_t v);
    logic [crfd_pkg::ACC_W:0] t;
    logic [R_W-1:0]           r;
    crfd_pkg::point_t         o;
    t = {v[crfd_pkg::ACC_W-1], v}
        + (crfd_pkg::ACC_W + 1)'(1 << (crfd_pkg::FRAC_SHIFT - 1));
    r = t[crfd_pkg::ACC_W:crfd_pkg::FRAC_SHIFT];
    if (!r[R_W-1] && (|r[R_W-1:crfd_pkg::PT_W-1])) begin
      o = {1'b0, {(crfd_pkg::PT_W-1){1'b1}}};
    end else if (r[R_W-1] && !(&r[R_W-1:crfd_pkg::PT_W-1])) begin
      o = {1'b1, {(crfd_pkg::PT_W-1){1'b0}}};
    end else begin
      o = r[crfd_pkg::PT_W-1:0];
    end
    return o;
  endfunction

  logic                         act_q;
  logic [crfd_pkg::STEP_W-1:0]  k_q;
  crfd_pkg::diff_set_t          cur_q;
  logic                         vld_q;
  crfd_pkg::point_t             vx_q, vy_q;
  logic                         ss_q, last_q;

  logic out_rdy, adv, fin, load;

  assign out_rdy = !vld_q || pop_i;
  assign adv     = act_q && out_rdy;
  assign fin     = adv && (k_q == crfd_pkg::STEP_W'(crfd_pkg::STEPS));
  assign load    = q_valid_i && (!act_q || fin);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      k_q   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
        k_q   <= '0;
      end else if (fin) begin
        act_q <= 1'b0;
      end else if (adv) begin
        k_q <= k_q + crfd_pkg::STEP_W'(1);
      end
      if (adv) begin
        vld_q <= 1'b1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end else if (adv) begin
      cur_q.x.x0 <= cur_q.x.x0 + cur_q.x.d1;
      cur_q.x.d1 <= cur_q.x.d1 + cur_q.x.d2;
      cur_q.x.d2 <= cur_q.x.d2 + cur_q.x.d3;
      cur_q.y.x0 <= cur_q.y.x0 + cur_q.y.d1;
      cur_q.y.d1 <= cur_q.y.d1 + cur_q.y.d2;
      cur_q.y.d2 <= cur_q.y.d2 + cur_q.y.d3;
    end
    if (adv) begin
      vx_q   <= to_vertex(cur_q.x.x0);
      vy_q   <= to_vertex(cur_q.y.x0);
      ss_q   <= (k_q == '0);
      last_q <= (k_q == crfd_pkg::STEP_W'(crfd_pkg::STEPS));
    end
  end

  assign empty_o       = !vld_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign strip_start_o = ss_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

>>> rtl/catmull_rom_forward_difference_core.sv
// Catmull-Rom curve core: control points in, curve vertices out.
// Input side is a queue write port: a point transfers when push is high and
// full is low. first_point_i starts a new list. The first three points of a
// list only fill the window; each later point closes a window and yields
// STEPS+1 (11) vertices, the first flagged strip_start_o, the last last_o.
// Output side is a queue read port: the oldest vertex shows while empty is
// low and transfers when pop is high.
// A window-filling point leaves full low. A window-closing point holds full
// high until its forward differences enter the queue: the front computes the
// coefficients, then six serial dividers (8 quotient bits a cycle) form the
// forward differences.
// A two-entry queue parts front and back. The back steps one vertex a cycle
// into an output register while that register is empty or pop is high, so
// 11 vertices per point.
// When pop is held low the output register holds, the back and then the
// queue fill, and full stays high; nothing is dropped.
// Reset clears the window, the point count, the queue and the output.
`default_nettype none

module catmull_rom_forward_difference_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              first_point_i,
  input  crfd_pkg::point_t  point_x_i,
  input  crfd_pkg::point_t  point_y_i,
  output logic              empty,
  input  logic              pop,
  output crfd_pkg::point_t  vertex_x_o,
  output crfd_pkg::point_t  vertex_y_o,
  output logic              strip_start_o,
  output logic              last_o
);

  logic                q_full, q_push, q_valid, q_pop;
  crfd_pkg::diff_set_t q_wdata, q_rdata;

  crfd_front u_front (
    .clk_i,
    .rst_ni,
    .push_i        (push),
    .full_o        (full),
    .first_point_i,
    .point_x_i,
    .point_y_i,
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  crfd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  crfd_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .vertex_x_o,
    .vertex_y_o,
    .strip_start_o,
    .last_o
  );

endmodule

`default_nettype wire

>>> rtl/crfd_checker.sv
`default_nettype none

module crfd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input crfd_pkg::point_t  vertex_x_o,
  input crfd_pkg::point_t  vertex_y_o,
  input logic              strip_start_o,
  input logic              last_o
);

  // stalled vertex holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(vertex_x_o) && $stable(vertex_y_o)
                       && $stable(strip_start_o) && $stable(last_o))
    else $error("stalled vertex changed");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(strip_start_o && last_o))
    else $error("strip start and last on one vertex");

  // inside a strip the next vertex follows at once
  a_mid_strip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_o |=> !empty && !strip_start_o)
    else $error("gap or restart inside a strip");

  a_new_strip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && last_o |=> empty || strip_start_o)
    else $error("strip did not restart after last vertex");

endmodule

bind catmull_rom_forward_difference_core crfd_checker u_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_POINTS = 120;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_SQUARE
  } rx_pattern_e;

  typedef struct {
    logic   drain;
    logic   first;
    point_t x;
    point_t y;
  } point_item_t;

  typedef struct {
    point_t x;
    point_t y;
    logic   strip_start;
    logic   last;
  } vertex_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   push = 1'b0;
  logic   full;
  logic   first_point = 1'b0;
  point_t point_x = '0;
  point_t point_y = '0;
  logic   empty;
  logic   pop = 1'b0;
  point_t vertex_x;
  point_t vertex_y;
  logic   strip_start;
  logic   last;

  point_item_t pending_points[$];
  vertex_t     expected_vertices[$];

  // predictor state
  point_t      win_x[3];
  point_t      win_y[3];
  int unsigned win_count = 0;

  int unsigned points_taken = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_cycle = 0;
  rx_pattern_e rx_pattern = RX_STREAM;
  logic        rx_hold = 1'b0;

  catmull_rom_forward_difference_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .first_point_i (first_point),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .empty         (empty),
    .pop           (pop),
    .vertex_x_o    (vertex_x),
    .vertex_y_o    (vertex_y),
    .strip_start_o (strip_start),
    .last_o        (last)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint round_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic diff_t curve_diffs(point_t w0, point_t w1, point_t w2, point_t p3);
    longint s;
    longint s3;
    longint a;
    longint b;
    longint c;
    diff_t  d;
    s  = longint'(STEPS);
    s3 = s * s * s;
    a  = -longint'(w0) + 3 * longint'(w1) - 3 * longint'(w2) + longint'(p3);
    b  = 2 * longint'(w0) - 5 * longint'(w1) + 4 * longint'(w2) - longint'(p3);
    c  = -longint'(w0) + longint'(w2);
    d.x0 = acc_t'(longint'(w1) * 65536);
    d.d1 = acc_t'(round_div((a + b * s + c * s * s) * 32768, s3));
    d.d2 = acc_t'(round_div((6 * a + 2 * b * s) * 32768, s3));
    d.d3 = acc_t'(round_div(6 * a * 32768, s3));
    return d;
  endfunction

  function automatic point_t vertex_of(acc_t v);
    longint r;
    r = (longint'(v) + 32768) >>> 16;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return point_t'(r);
  endfunction

  function automatic void shift_window(point_t px, point_t py);
    win_x[0] = win_x[1];
    win_x[1] = win_x[2];
    win_x[2] = px;
    win_y[0] = win_y[1];
    win_y[1] = win_y[2];
    win_y[2] = py;
  endfunction

  function automatic void predict_vertices(logic first, point_t px, point_t py);
    diff_t   dx;
    diff_t   dy;
    vertex_t v;
    if (first) begin
      for (int i = 0; i < 3; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
      shift_window(px, py);
      win_count = 1;
      return;
    end
    if (win_count < 3) begin
      shift_window(px, py);
      win_count++;
      return;
    end
    dx = curve_diffs(win_x[0], win_x[1], win_x[2], px);
    dy = curve_diffs(win_y[0], win_y[1], win_y[2], py);
    for (int k = 0; k <= STEPS; k++) begin
      if (k > 0) begin
        dx.x0 = dx.x0 + dx.d1;
        dx.d1 = dx.d1 + dx.d2;
        dx.d2 = dx.d2 + dx.d3;
        dy.x0 = dy.x0 + dy.d1;
        dy.d1 = dy.d1 + dy.d2;
        dy.d2 = dy.d2 + dy.d3;
      end
      v.x = vertex_of(dx.x0);
      v.y = vertex_of(dy.x0);
      v.strip_start = (k == 0);
      v.last = (k == STEPS);
      expected_vertices.push_back(v);
    end
    shift_window(px, py);
  endfunction

  task automatic add_point(logic first, int x, int y);
    point_item_t p;
    p.drain = 1'b0;
    p.first = first;
    p.x = point_t'(x);
    p.y = point_t'(y);
    pending_points.push_back(p);
  endtask

  task automatic add_drain();
    point_item_t p;
    p.drain = 1'b1;
    p.first = 1'b0;
    p.x = '0;
    p.y = '0;
    pending_points.push_back(p);
  endtask

  function automatic int rand_coord(int unsigned spread);
    case (spread)
      0: return int'($urandom_range(0, 8191)) - 4096;
      1: return int'(point_t'($urandom));
      2: return 8388607 - int'($urandom_range(0, 255));
      default: return -8388608 + int'($urandom_range(0, 255));
    endcase
  endfunction

  // sender: bursts with gaps, drain markers wait for every vertex
  always @(posedge clk_i) begin
    point_item_t p;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_vertices(first_point, point_x, point_y);
        points_taken++;
      end
      if (push && full) begin
        // stalled, hold the offered point
      end else if (gap_left > 0) begin
        push <= 1'b0;
        gap_left--;
      end else if (pending_points.size() == 0) begin
        push <= 1'b0;
      end else if (pending_points[0].drain) begin
        push <= 1'b0;
        if (expected_vertices.size() == 0) void'(pending_points.pop_front());
      end else begin
        p = pending_points.pop_front();
        push <= 1'b1;
        first_point <= p.first;
        point_x <= p.x;
        point_y <= p.y;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left = $urandom_range(0, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern and vertex check
  always @(posedge clk_i) begin
    vertex_t e;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_vertices.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected vertex x=%0d y=%0d start=%0b last=%0b",
                     vertex_x, vertex_y, strip_start, last);
        end else begin
          e = expected_vertices.pop_front();
          if (vertex_x !== e.x || vertex_y !== e.y || strip_start !== e.strip_start ||
              last !== e.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("vertex mismatch exp x=%0d y=%0d start=%0b last=%0b, got x=%0d y=%0d start=%0b last=%0b",
                       e.x, e.y, e.strip_start, e.last,
                       vertex_x, vertex_y, strip_start, last);
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      if (rx_hold) begin
        pop <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_STREAM: pop <= 1'b1;
          RX_COIN:   pop <= $urandom_range(0, 1);
          RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          default:   pop <= rx_cycle[3];
        endcase
      end
    end
  end

  // long receiver hold-off so the core backs up and stalls the sender
  initial begin
    while (points_taken < 45) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("catmull_rom_forward_difference_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_points;
    int unsigned list_len;
    int unsigned spread;

    // window fill straight from reset, no list start
    add_point(1'b0, 256, 512);
    add_point(1'b0, -768, 1024);
    add_point(1'b0, 2560, -3840);
    add_point(1'b0, 5120, 7680);
    // extremes, saturating vertices
    add_point(1'b1, -8388608, -8388608);
    add_point(1'b0, 8388607, 8388607);
    add_point(1'b0, -8388608, 8388607);
    add_point(1'b0, 8388607, -8388608);
    add_point(1'b0, 0, 0);
    add_point(1'b0, -1, -1);
    // list restarted before the window is full
    add_point(1'b1, 0, 0);
    add_point(1'b0, 0, 0);
    add_point(1'b1, 1, -1);
    add_point(1'b0, -2, 2);
    add_point(1'b0, 3, -3);
    add_point(1'b0, 8388607, -8388608);
    add_point(1'b0, -8388608, 8388607);
    // list start while the window is full
    add_point(1'b1, -1, -1);
    add_point(1'b0, -1, -1);
    add_point(1'b0, -1, -1);
    add_point(1'b0, -1, -1);
    add_drain();

    rand_points = 0;
    while (rand_points < RANDOM_POINTS) begin
      list_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 9);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < list_len; i++) begin
        add_point(i == 0 || $urandom_range(0, 39) == 0,
                  rand_coord(spread == 0 ? 0 : $urandom_range(1, 3)),
                  rand_coord(spread == 0 ? 0 : $urandom_range(1, 3)));
        rand_points++;
      end
      if (rand_points >= 60 && rand_points < 60 + list_len) add_drain();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_points.size() != 0 || push) @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_vertices.size() == 0) begin
      $display("catmull_rom_forward_difference_core verification clean");
    end else begin
      $display("catmull_rom_forward_difference_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/crfd_pkg.sv
rtl/crfd_div.sv
rtl/crfd_front.sv
rtl/crfd_queue.sv
rtl/crfd_back.sv
rtl/catmull_rom_forward_difference_core.sv
rtl/crfd_checker.sv
verif/tb_top.sv
